@@ rtl/core/nap_pkg.sv @@
// ----------------------------------------------------------------------------
// nap_pkg
// Shared types and constants of the notification attribute parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nap_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_TITLE   = 2'd0;
  localparam logic [1:0] KIND_MESSAGE = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Verdict status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_BAD_COMMAND = 3'd2;
  localparam logic [2:0] ST_CUT_LENGTH  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG    = 3'd4;
  localparam logic [2:0] ST_OVERRUN     = 3'd5;
  localparam logic [2:0] ST_UNKNOWN_ID  = 3'd6;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TITLE_CODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TITLE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LIMIT = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Register values after reset.
  localparam logic [7:0]  RST_COMMAND_CODE  = 8'd0;
  localparam logic [7:0]  RST_TITLE_CODE    = 8'd1;
  localparam logic [7:0]  RST_MESSAGE_CODE  = 8'd3;
  localparam logic [15:0] RST_TITLE_LIMIT   = 16'd50;
  localparam logic [15:0] RST_MESSAGE_LIMIT = 16'd100;

  typedef struct packed {
    logic [7:0]  command_code;
    logic [7:0]  title_code;
    logic [7:0]  message_code;
    logic [15:0] title_limit;
    logic [15:0] message_limit;
  } nap_cfg_t;

  // One registered input item on its way to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] byte_in;
    logic       last_byte;
  } nap_item_t;

endpackage : nap_pkg

`default_nettype wire

@@ rtl/core/nap_cfg.sv @@
// ----------------------------------------------------------------------------
// nap_cfg
// Configuration register file of the notification attribute parser.
// ----------------------------------------------------------------------------
`default_nettype none

module nap_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [nap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nap_pkg::CFG_DATA_W-1:0]   cfg_data,
  output nap_pkg::nap_cfg_t                     cfg
);

  nap_pkg::nap_cfg_t cfg_r;
  nap_pkg::nap_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        nap_pkg::CFG_COMMAND_CODE:  cfg_nxt.command_code  = cfg_data[7:0];
        nap_pkg::CFG_TITLE_CODE:    cfg_nxt.title_code    = cfg_data[7:0];
        nap_pkg::CFG_MESSAGE_CODE:  cfg_nxt.message_code  = cfg_data[7:0];
        nap_pkg::CFG_TITLE_LIMIT:   cfg_nxt.title_limit   = cfg_data;
        nap_pkg::CFG_MESSAGE_LIMIT: cfg_nxt.message_limit = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.command_code  <= nap_pkg::RST_COMMAND_CODE;
      cfg_r.title_code    <= nap_pkg::RST_TITLE_CODE;
      cfg_r.message_code  <= nap_pkg::RST_MESSAGE_CODE;
      cfg_r.title_limit   <= nap_pkg::RST_TITLE_LIMIT;
      cfg_r.message_limit <= nap_pkg::RST_MESSAGE_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule : nap_cfg

`default_nettype wire

@@ rtl/core/nap_in_stage.sv @@
// ----------------------------------------------------------------------------
// nap_in_stage
// Input register: holds one byte item until the parser stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nap_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_byte_in,
  input  wire logic          in_last_byte,
  input  wire logic          advance,
  output nap_pkg::nap_item_t item
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;

  // The held item leaves whenever the parser stage advances.
  assign in_stall = vld_r && !advance;
  assign load     = !in_stall;
  assign vld_nxt  = load ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      byte_r <= in_byte_in;
      last_r <= in_last_byte;
    end
  end

  assign item.valid     = vld_r;
  assign item.byte_in   = byte_r;
  assign item.last_byte = last_r;

endmodule : nap_in_stage

`default_nettype wire

@@ rtl/core/nap_parse.sv @@
// ----------------------------------------------------------------------------
// nap_parse
// Message parser and result register, one byte item per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module nap_parse (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire nap_pkg::nap_cfg_t  cfg,
  input  wire nap_pkg::nap_item_t item,
  output logic               advance,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_data_byte,
  output logic [31:0]        out_notification_uid,
  output logic [2:0]         out_status
);

  typedef enum logic [2:0] {
    PH_COMMAND,
    PH_UID,
    PH_ATTR_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] uid_r, uid_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] left_r, left_nxt;
  logic        is_msg_r, is_msg_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [31:0] ouid_r, ouid_nxt;
  logic [2:0]  status_r, status_nxt;

  logic        go;
  logic        has_data;
  logic [7:0]  b;
  logic [15:0] full_len;
  logic [15:0] limit;
  logic [2:0]  verdict;

  assign advance  = !out_valid_r || !out_stall;
  assign go       = item.valid && advance;
  assign b        = item.byte_in;
  assign full_len = {b, len_lo_r};
  assign limit    = is_msg_r ? cfg.message_limit : cfg.title_limit;

  always_comb begin
    phase_nxt  = phase_r;
    uid_nxt    = uid_r;
    cnt_nxt    = cnt_r;
    len_lo_nxt = len_lo_r;
    left_nxt   = left_r;
    is_msg_nxt = is_msg_r;
    err_nxt    = err_r;
    has_data   = 1'b0;

    case (phase_r)
      PH_COMMAND: begin
        if (b != cfg.command_code) begin
          err_nxt = nap_pkg::ST_BAD_COMMAND;
        end
        uid_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = PH_UID;
      end
      PH_UID: begin
        case (cnt_r)
          2'd0:    uid_nxt[7:0]   = uid_r[7:0]   | b;
          2'd1:    uid_nxt[15:8]  = uid_r[15:8]  | b;
          2'd2:    uid_nxt[23:16] = uid_r[23:16] | b;
          default: uid_nxt[31:24] = uid_r[31:24] | b;
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          phase_nxt = PH_ATTR_ID;
        end
      end
      default: begin
        // Once an error is recorded, records are no longer parsed.
        if (err_r == nap_pkg::ST_OK) begin
          case (phase_r)
            PH_ATTR_ID: begin
              if (b == cfg.title_code) begin
                is_msg_nxt = 1'b0;
                phase_nxt  = PH_LEN_LO;
              end else if (b == cfg.message_code) begin
                is_msg_nxt = 1'b1;
                phase_nxt  = PH_LEN_LO;
              end else begin
                err_nxt = nap_pkg::ST_UNKNOWN_ID;
              end
            end
            PH_LEN_LO: begin
              len_lo_nxt = b;
              phase_nxt  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              if (full_len > limit) begin
                err_nxt = nap_pkg::ST_TOO_LONG;
              end else begin
                left_nxt  = full_len;
                phase_nxt = (full_len != '0) ? PH_DATA : PH_ATTR_ID;
              end
            end
            PH_DATA: begin
              has_data = 1'b1;
              left_nxt = left_r - 16'd1;
              if (left_r == 16'd1) begin
                phase_nxt = PH_ATTR_ID;
              end
            end
            default: begin
              phase_nxt = PH_ATTR_ID;
            end
          endcase
        end
      end
    endcase

    if (phase_nxt == PH_COMMAND || phase_nxt == PH_UID) begin
      verdict = nap_pkg::ST_SHORT;
    end else if (err_nxt != nap_pkg::ST_OK) begin
      verdict = err_nxt;
    end else if (phase_nxt == PH_LEN_LO || phase_nxt == PH_LEN_HI) begin
      verdict = nap_pkg::ST_CUT_LENGTH;
    end else if (phase_nxt == PH_DATA) begin
      verdict = nap_pkg::ST_OVERRUN;
    end else begin
      verdict = nap_pkg::ST_OK;
    end

    ouid_nxt = uid_nxt;
    if (item.last_byte) begin
      kind_nxt      = nap_pkg::KIND_VERDICT;
      data_nxt      = has_data ? b : 8'd0;
      status_nxt    = verdict;
      out_valid_nxt = 1'b1;
      // The message is over: all message state returns to its reset value.
      phase_nxt  = PH_COMMAND;
      uid_nxt    = '0;
      cnt_nxt    = '0;
      len_lo_nxt = '0;
      left_nxt   = '0;
      is_msg_nxt = 1'b0;
      err_nxt    = nap_pkg::ST_OK;
    end else begin
      kind_nxt      = is_msg_r ? nap_pkg::KIND_MESSAGE : nap_pkg::KIND_TITLE;
      data_nxt      = b;
      status_nxt    = nap_pkg::ST_OK;
      out_valid_nxt = has_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_COMMAND;
      uid_r       <= '0;
      cnt_r       <= '0;
      len_lo_r    <= '0;
      left_r      <= '0;
      is_msg_r    <= 1'b0;
      err_r       <= nap_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else if (go) begin
      phase_r     <= phase_nxt;
      uid_r       <= uid_nxt;
      cnt_r       <= cnt_nxt;
      len_lo_r    <= len_lo_nxt;
      left_r      <= left_nxt;
      is_msg_r    <= is_msg_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end else if (advance) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      kind_r   <= kind_nxt;
      data_r   <= data_nxt;
      ouid_r   <= ouid_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = kind_r;
  assign out_data_byte        = data_r;
  assign out_notification_uid = ouid_r;
  assign out_status           = status_r;

endmodule : nap_parse

`default_nettype wire

@@ rtl/core/notification_attribute_parser.sv @@
// Path: an accepted byte is held in the input register, then the parser stage
// writes its result, if it has one, into the result register.
// Throughput: one byte item per cycle; the parser stage advances whenever the result
// register is empty or its result is being taken.
// Reset (rst_n low, synchronous): message state clears, registers load their defaults.
// ----------------------------------------------------------------------------
// notification_attribute_parser
// Parses a notification attribute response byte stream, passes title and
// message bytes out and gives a verdict with id and status on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module notification_attribute_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_byte_in,
  input  wire logic                           in_last_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_kind,
  output logic [7:0]                          out_data_byte,
  output logic [31:0]                         out_notification_uid,
  output logic [2:0]                          out_status,
  input  wire logic                           cfg_we,
  input  wire logic [nap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nap_pkg::CFG_DATA_W-1:0] cfg_data
);

  nap_pkg::nap_cfg_t  cfg;
  nap_pkg::nap_item_t item;
  logic               advance;

  nap_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nap_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .item         (item)
  );

  nap_parse u_parse (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .item                 (item),
    .advance              (advance),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_data_byte        (out_data_byte),
    .out_notification_uid (out_notification_uid),
    .out_status           (out_status)
  );

endmodule : notification_attribute_parser

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the notification attribute parser. Streams response
// messages (directed, well-formed random, truncated and noise) through the
// byte channel under random bursts and result stalls, tracks the parse in a
// local model and compares every result item field by field.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } msg_byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] uid;
    logic [2:0]  status;
  } parse_result_t;

  typedef enum logic [2:0] {
    PHASE_COMMAND,
    PHASE_UID,
    PHASE_ATTR_ID,
    PHASE_LEN_LO,
    PHASE_LEN_HI,
    PHASE_DATA
  } parse_phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte_in = 8'h00;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_data_byte;
  logic [31:0]          out_notification_uid;
  logic [2:0]           out_status;
  logic                 cfg_we = 1'b0;
  logic [nap_pkg::CFG_IDX_W-1:0]  cfg_index = nap_pkg::CFG_COMMAND_CODE;
  logic [nap_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  notification_attribute_parser uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_in          (in_byte_in),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_notification_uid(out_notification_uid),
    .out_status          (out_status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  msg_byte_t     pending_bytes[$];
  parse_result_t expected_results[$];
  logic [7:0]    msg_bytes[$];
  int unsigned   bytes_queued = 0;
  int unsigned   bytes_taken = 0;
  int unsigned   error_count = 0;
  bit            in_taken = 1'b0;

  // Register copies.
  logic [7:0]  cmd_code = nap_pkg::RST_COMMAND_CODE;
  logic [7:0]  title_code = nap_pkg::RST_TITLE_CODE;
  logic [7:0]  message_code = nap_pkg::RST_MESSAGE_CODE;
  logic [15:0] title_limit = nap_pkg::RST_TITLE_LIMIT;
  logic [15:0] message_limit = nap_pkg::RST_MESSAGE_LIMIT;

  // Parse state of the message in flight.
  parse_phase_t phase_q = PHASE_COMMAND;
  logic [31:0]  uid_q = '0;
  logic [1:0]   uid_count_q = '0;
  logic [15:0]  rec_len_q = '0;
  logic [15:0]  rec_left_q = '0;
  logic         rec_is_msg_q = 1'b0;
  logic [2:0]   err_q = nap_pkg::ST_OK;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("notification_attribute_parser regression: fail");
    $finish;
  end

  function automatic void clear_parse_state();
    phase_q = PHASE_COMMAND;
    uid_q = '0;
    uid_count_q = '0;
    rec_len_q = '0;
    rec_left_q = '0;
    rec_is_msg_q = 1'b0;
    err_q = nap_pkg::ST_OK;
  endfunction

  // Advances the parse by one accepted byte and queues the result it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    parse_result_t res;
    logic          has_data;
    logic [15:0]   limit;
    has_data = 1'b0;
    res = '0;
    case (phase_q)
      PHASE_COMMAND: begin
        if (b != cmd_code) err_q = nap_pkg::ST_BAD_COMMAND;
        uid_q = '0;
        uid_count_q = '0;
        phase_q = PHASE_UID;
      end
      PHASE_UID: begin
        uid_q = uid_q | (32'(b) << (8 * uid_count_q));
        if (uid_count_q == 2'd3) phase_q = PHASE_ATTR_ID;
        uid_count_q = uid_count_q + 2'd1;
      end
      default: begin
        if (err_q == nap_pkg::ST_OK) begin
          case (phase_q)
            PHASE_ATTR_ID: begin
              // A title match wins when both codes are equal.
              if (b == title_code) begin
                rec_is_msg_q = 1'b0;
                phase_q = PHASE_LEN_LO;
              end else if (b == message_code) begin
                rec_is_msg_q = 1'b1;
                phase_q = PHASE_LEN_LO;
              end else begin
                err_q = nap_pkg::ST_UNKNOWN_ID;
              end
            end
            PHASE_LEN_LO: begin
              rec_len_q = {8'h00, b};
              phase_q = PHASE_LEN_HI;
            end
            PHASE_LEN_HI: begin
              limit = rec_is_msg_q ? message_limit : title_limit;
              rec_len_q = {b, rec_len_q[7:0]};
              if (rec_len_q > limit) begin
                err_q = nap_pkg::ST_TOO_LONG;
              end else begin
                rec_left_q = rec_len_q;
                phase_q = (rec_len_q != 0) ? PHASE_DATA : PHASE_ATTR_ID;
              end
            end
            PHASE_DATA: begin
              has_data = 1'b1;
              rec_left_q = rec_left_q - 16'd1;
              if (rec_left_q == 0) phase_q = PHASE_ATTR_ID;
            end
            default: phase_q = PHASE_ATTR_ID;
          endcase
        end
      end
    endcase

    if (last) begin
      res.kind = nap_pkg::KIND_VERDICT;
      res.data_byte = has_data ? b : 8'h00;
      res.uid = uid_q;
      if (phase_q == PHASE_COMMAND || phase_q == PHASE_UID) begin
        res.status = nap_pkg::ST_SHORT;
      end else if (err_q != nap_pkg::ST_OK) begin
        res.status = err_q;
      end else if (phase_q == PHASE_LEN_LO || phase_q == PHASE_LEN_HI) begin
        res.status = nap_pkg::ST_CUT_LENGTH;
      end else if (phase_q == PHASE_DATA) begin
        res.status = nap_pkg::ST_OVERRUN;
      end else begin
        res.status = nap_pkg::ST_OK;
      end
      expected_results.push_back(res);
      clear_parse_state();
    end else if (has_data) begin
      res.kind = rec_is_msg_q ? nap_pkg::KIND_MESSAGE : nap_pkg::KIND_TITLE;
      res.data_byte = b;
      res.uid = uid_q;
      res.status = nap_pkg::ST_OK;
      expected_results.push_back(res);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Result checks come before prediction, since a byte taken at this edge
  // cannot have produced a result yet.
  always @(posedge clk) begin
    parse_result_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: kind %0d, data 0x%0h, uid 0x%0h, status %0d",
                 out_kind, out_data_byte, out_notification_uid, out_status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("data_byte", 32'(want.data_byte), 32'(out_data_byte));
          check_field("notification_uid", want.uid, out_notification_uid);
          check_field("status", 32'(want.status), 32'(out_status));
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        bytes_taken++;
        parse_byte(in_byte_in, in_last_byte);
      end
    end
  end

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    msg_byte_t nxt;
    logic      next_valid;
    next_valid = in_valid && !in_taken;
    if (rst_n && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        in_byte_in <= nxt.value;
        in_last_byte <= nxt.last;
        next_valid = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // Now and then a long burst with no gaps at all.
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 200);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(0, 6);
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  int unsigned stall_span = 0;
  int unsigned stall_mode = 0;

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(4, 40);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  task automatic flush_message();
    msg_byte_t item;
    foreach (msg_bytes[i]) begin
      item.value = msg_bytes[i];
      item.last = (i == msg_bytes.size() - 1);
      pending_bytes.push_back(item);
      bytes_queued++;
    end
    msg_bytes.delete();
  endtask

  task automatic write_reg(input logic [nap_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      nap_pkg::CFG_COMMAND_CODE: cmd_code = value[7:0];
      nap_pkg::CFG_TITLE_CODE:   title_code = value[7:0];
      nap_pkg::CFG_MESSAGE_CODE: message_code = value[7:0];
      nap_pkg::CFG_TITLE_LIMIT:  title_limit = value;
      default:                   message_limit = value;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] cmd, input logic [7:0] tcode,
                                input logic [7:0] mcode, input logic [15:0] tlim,
                                input logic [15:0] mlim);
    write_reg(nap_pkg::CFG_COMMAND_CODE, 16'(cmd));
    write_reg(nap_pkg::CFG_TITLE_CODE, 16'(tcode));
    write_reg(nap_pkg::CFG_MESSAGE_CODE, 16'(mcode));
    write_reg(nap_pkg::CFG_TITLE_LIMIT, tlim);
    write_reg(nap_pkg::CFG_MESSAGE_LIMIT, mlim);
  endtask

  // Holds until every byte is taken and every result has arrived, then lets
  // the pipeline settle for bytes that cause no result.
  task automatic drain();
    while (bytes_taken != bytes_queued || expected_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic build_random_message();
    int unsigned roll;
    int unsigned len;
    int unsigned limit;
    int unsigned cut;
    logic [7:0]  id;
    bit          over;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
    end else begin
      msg_bytes.push_back(roll < 12 ? 8'($urandom) : cmd_code);
      repeat (4) msg_bytes.push_back(8'($urandom));
      repeat ($urandom_range(0, 3)) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          id = title_code;
          limit = 32'(title_limit);
        end else if (roll < 90) begin
          id = message_code;
          limit = 32'(message_limit);
        end else begin
          id = 8'($urandom);
          limit = 8;
        end
        over = ($urandom_range(0, 9) == 0) && (limit < 65535);
        if (over) len = limit + 1 + ($urandom % (65535 - limit));
        else if (limit <= 8 && $urandom_range(0, 4) == 0) len = limit;
        else len = $urandom_range(0, (limit < 6) ? limit : 6);
        msg_bytes.push_back(id);
        msg_bytes.push_back(len[7:0]);
        msg_bytes.push_back(len[15:8]);
        if (!over) repeat (len) msg_bytes.push_back(8'($urandom));
      end
      // Some messages are cut short anywhere, including inside the header.
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end
    flush_message();
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned target;
    target = bytes_queued + budget;
    while (bytes_queued < target) build_random_message();
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed messages under the reset settings.
    msg_bytes = '{8'h00};
    flush_message();
    msg_bytes = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00};
    flush_message();
    msg_bytes = '{8'h00, 8'h78, 8'h56, 8'h34, 8'h12, 8'h01, 8'h01, 8'h00, 8'hFF,
                  8'h03, 8'h01, 8'h00, 8'h00};
    flush_message();
    msg_bytes = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h77};
    flush_message();
    drain();
    run_random(150);

    apply_settings(8'hFF, 8'h00, 8'hFF, 16'h0000, 16'hFFFF);
    run_random(150);
    apply_settings(8'h5A, 8'h07, 8'h07, 16'd4, 16'd3);
    run_random(150);
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)));
    run_random(150);
    apply_settings(8'h00, 8'hFF, 8'h00, 16'hFFFF, 16'h0000);
    run_random(150);

    if (error_count == 0) begin
      $display("notification_attribute_parser regression: pass");
    end else begin
      $display("notification_attribute_parser regression: fail");
    end
    $finish;
  end

endmodule
